@@ sv/sptm_pkg.sv @@
// shared constants and codes for the sv39 page table manager
package sptm_pkg;
    localparam int POOL_PAGES_DEF = 64;

    localparam int VA_W    = 39;
    localparam int PA_W    = 56;
    localparam int PPN_W   = 44;
    localparam int PTE_W   = 54;
    localparam int VPN_W   = 9;
    localparam int CNT_W   = 16;
    localparam int COLOR_W = 16;

    typedef enum logic [1:0] {
        OP_MAP     = 2'd0,
        OP_UNMAP   = 2'd1,
        OP_RESOLVE = 2'd2,
        OP_BAD     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DENIED  = 2'd2,
        ST_NO_MEM  = 2'd3
    } t_status;

    localparam logic CFG_PARTITION = 1'b0;
    localparam logic CFG_BASE      = 1'b1;

    localparam logic [9:0] F_V = 10'h001;
    localparam logic [9:0] F_R = 10'h002;
    localparam logic [9:0] F_W = 10'h004;
    localparam logic [9:0] F_X = 10'h008;
    localparam logic [9:0] F_U = 10'h010;
    localparam logic [9:0] F_A = 10'h040;
    localparam logic [9:0] F_D = 10'h080;
endpackage

@@ sv/sv39_page_table_manager.sv @@
// sv39 page table manager: walker sequencer over one table memory
// resolve walks up to three levels; map/unmap walk each page in turn, and map zero-sweeps each table page it allocates
// unaligned map/unmap, bad map colors, bad codes and zero counts finish without a table walk
// one request at a time; the single memory port sets the per-page walk cost
// after reset the root page is swept to zero; no request is accepted until the sweep ends
// reset also clears the output valid, partition and base registers and sets one table page in use
module sv39_page_table_manager #(
    parameter int POOL_PAGES = sptm_pkg::POOL_PAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_operation,
    input  logic [sptm_pkg::VA_W-1:0]    i_vaddr,
    input  logic [sptm_pkg::PA_W-1:0]    i_paddr,
    input  logic [sptm_pkg::CNT_W-1:0]   i_page_count,
    input  logic [2:0]                   i_perms,
    input  logic [sptm_pkg::COLOR_W-1:0] i_color,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic                         o_found,
    output logic [sptm_pkg::PA_W-1:0]    o_phys_addr,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [sptm_pkg::PPN_W-1:0]   i_cfg_data
);
    import sptm_pkg::*;

    localparam int PW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int UW    = $clog2(POOL_PAGES + 1);
    localparam int DEPTH = POOL_PAGES * 512;
    localparam int AW    = PW + VPN_W;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_START = 7'b0000100,
        S_RD    = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_ALLOC = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    logic [PTE_W-1:0] r_mem [DEPTH];

    t_state             r_state;
    logic [1:0]         r_op;
    logic [VA_W-1:0]    r_va;
    logic [PA_W-1:0]    r_pa;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_n;
    logic [2:0]         r_perms;
    logic [COLOR_W-1:0] r_color;
    logic [1:0]         r_level;
    logic [PW-1:0]      r_page;
    logic [UW-1:0]      r_used;
    logic [VPN_W-1:0]   r_cnt;
    logic [PTE_W-1:0]   r_rdata;
    logic [1:0]         r_res_status;
    logic               r_res_found;
    logic [PA_W-1:0]    r_res_phys;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic               r_found;
    logic [PA_W-1:0]    r_phys;
    logic [7:0]         r_part;
    logic [PPN_W-1:0]   r_base;

    logic [VPN_W-1:0] w_vpn;
    logic [AW-1:0]    w_addr;
    logic [PPN_W-1:0] w_idx;
    logic             w_follow;
    logic [9:0]       w_flags;
    logic [PTE_W-1:0] w_ptr;
    logic [PTE_W-1:0] w_leaf;
    logic             w_last;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [PTE_W-1:0] w_wdata;

    always_comb begin
        case (r_level)
            2'd2:    w_vpn = r_va[38:30];
            2'd1:    w_vpn = r_va[29:21];
            default: w_vpn = r_va[20:12];
        endcase
    end

    assign w_addr   = {r_page, w_vpn};
    assign w_idx    = r_rdata[PTE_W-1:10] - r_base;
    assign w_follow = r_rdata[0] && (w_idx < {{(PPN_W-UW){1'b0}}, r_used});
    assign w_ptr    = {r_base + {{(PPN_W-UW){1'b0}}, r_used}, F_V};
    assign w_flags  = F_V | F_A | F_D | (r_perms[0] ? F_R : 10'h0)
                    | (r_perms[1] ? F_W : 10'h0) | (r_perms[2] ? F_X : 10'h0)
                    | ((r_part != 8'd0) ? F_U : 10'h0);
    assign w_leaf   = {r_pa[PA_W-1:12], w_flags};
    assign w_last   = (r_n + 16'd1) == r_count;

    // single write port: sweeps, pointer installs and leaf updates
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr;
        w_wdata = '0;
        case (r_state)
            S_INIT, S_ALLOC: begin
                w_we    = 1'b1;
                w_waddr = {r_page, r_cnt};
            end
            S_WAIT: begin
                if (r_level != 2'd0) begin
                    if (!w_follow && r_op == OP_MAP && r_used < UW'(POOL_PAGES)) begin
                        w_we    = 1'b1;
                        w_wdata = w_ptr;
                    end
                end else if (r_op == OP_MAP) begin
                    w_we    = !r_rdata[0];
                    w_wdata = w_leaf;
                end else if (r_op == OP_UNMAP) begin
                    w_we    = 1'b1;
                end
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_page      <= '0;
            r_cnt       <= '0;
            r_used      <= UW'(1);
            r_out_valid <= 1'b0;
            r_part      <= '0;
            r_base      <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_PARTITION) begin
                    r_part <= i_cfg_data[7:0];
                end else begin
                    r_base <= i_cfg_data;
                end
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + 9'd1;
                    if (r_cnt == 9'h1FF) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_operation;
                        r_va    <= i_vaddr;
                        r_pa    <= i_paddr;
                        r_count <= i_page_count;
                        r_perms <= i_perms;
                        r_color <= i_color;
                        r_n     <= '0;
                        r_level <= 2'd2;
                        r_page  <= '0;
                        r_res_status <= ST_OK;
                        r_res_found  <= 1'b0;
                        r_res_phys   <= '0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_RD;
                    if (r_op == OP_BAD) begin
                        r_res_status <= ST_INVALID;
                        r_state      <= S_DONE;
                    end else if (r_op == OP_MAP && (r_va[11:0] != 12'd0
                                 || r_pa[11:0] != 12'd0 || r_color[0])) begin
                        r_res_status <= ST_INVALID;
                        r_state      <= S_DONE;
                    end else if (r_op == OP_MAP && r_color != 16'd0
                                 && r_color != {12'd0, r_va[15:12]}) begin
                        r_res_status <= ST_DENIED;
                        r_state      <= S_DONE;
                    end else if (r_op == OP_UNMAP && r_va[11:0] != 12'd0) begin
                        r_res_status <= ST_INVALID;
                        r_state      <= S_DONE;
                    end else if (r_op != OP_RESOLVE && r_count == 16'd0) begin
                        r_state <= S_DONE;
                    end
                end
                S_RD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (r_level != 2'd0) begin
                        if (w_follow) begin
                            r_page  <= w_idx[PW-1:0];
                            r_level <= r_level - 2'd1;
                            r_state <= S_RD;
                        end else if (r_op == OP_MAP) begin
                            if (r_used >= UW'(POOL_PAGES)) begin
                                r_res_status <= ST_NO_MEM;
                                r_state      <= S_DONE;
                            end else begin
                                r_page  <= r_used[PW-1:0];
                                r_used  <= r_used + UW'(1);
                                r_level <= r_level - 2'd1;
                                r_cnt   <= '0;
                                r_state <= S_ALLOC;
                            end
                        end else if (r_op == OP_RESOLVE || w_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_n     <= r_n + 16'd1;
                            r_va    <= r_va + 39'h1000;
                            r_level <= 2'd2;
                            r_page  <= '0;
                            r_state <= S_RD;
                        end
                    end else if (r_op == OP_RESOLVE) begin
                        r_res_found <= r_rdata[0];
                        r_res_phys  <= r_rdata[0] ? {r_rdata[PTE_W-1:10], r_va[11:0]} : '0;
                        r_state     <= S_DONE;
                    end else if (r_op == OP_MAP && r_rdata[0]) begin
                        r_res_status <= ST_INVALID;
                        r_state      <= S_DONE;
                    end else if (w_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_n     <= r_n + 16'd1;
                        r_va    <= r_va + 39'h1000;
                        r_pa    <= r_pa + 56'h1000;
                        r_level <= 2'd2;
                        r_page  <= '0;
                        r_state <= S_RD;
                    end
                end
                S_ALLOC: begin
                    r_cnt <= r_cnt + 9'd1;
                    if (r_cnt == 9'h1FF) begin
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_status    <= r_res_status;
                        r_found     <= r_res_found;
                        r_phys      <= r_res_phys;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_phys_addr = r_phys;
    assign o_cfg_ready = 1'b1;
endmodule

@@ sv/sptm_checker.sv @@
// port-level checks for the sv39 page table manager
module sptm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [1:0]                   o_status,
    input logic                         o_found,
    input logic [sptm_pkg::PA_W-1:0]    o_phys_addr
);
    import sptm_pkg::*;

    // a result stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
        && $stable(o_phys_addr))
        else $error("result dropped or changed while stalled");

    // one request at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready while a request is in work");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == ST_OK)
        else $error("found with error status");

    a_phys_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_phys_addr == '0)
        else $error("address without a mapping");
endmodule

bind sv39_page_table_manager sptm_checker u_sptm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_found     (o_found),
    .o_phys_addr (o_phys_addr)
);
